/* src/pixel_dirty_run_coalescer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pixel dirty run coalescer
// Concurrent assertion shorthands clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_DIRTY_RUN_COALESCER_TOP_MACROS_SVH
`define PIXEL_DIRTY_RUN_COALESCER_TOP_MACROS_SVH

`ifndef SYNTH
`define PDRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pdrc assertion failed");
`define PDRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pdrc assertion failed");
`else
`define PDRC_ASSERT_IMP(lbl, ante, cons)
`define PDRC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/pdrc_pkg.sv */
// ----------------------------------------------------------------------------
// pdrc_pkg
// Shared constants and types of the pixel dirty run coalescer.
// ----------------------------------------------------------------------------
package pdrc_pkg;

    localparam int PANEL_PIXELS_DEF = 64;
    localparam int FACES_DEF        = 6;

    localparam int IDX_W   = 9;
    localparam int COLOR_W = 24;
    localparam int LEN_W   = 9;
    localparam int FACE_W  = 3;

    typedef struct packed {
        logic [IDX_W-1:0]  run_first;
        logic [LEN_W-1:0]  run_length;
        logic [FACE_W-1:0] first_face;
        logic [FACE_W-1:0] last_face;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] data;
    } store_wr_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

endpackage

/* src/pdrc_ram.sv */
// ----------------------------------------------------------------------------
// pdrc_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pdrc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pdrc_update.sv */
// ----------------------------------------------------------------------------
// pdrc_update
// Compare stage: checks the stored color, writes dirty pixels back and
// tracks the open run, closing it into a result item when required.
// ----------------------------------------------------------------------------
module pdrc_update #(
    parameter int PANEL_PIXELS = pdrc_pkg::PANEL_PIXELS_DEF,
    parameter int FACES        = pdrc_pkg::FACES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_take,
    input  logic                            in_range,
    input  logic [pdrc_pkg::IDX_W-1:0]      in_idx,
    input  logic [pdrc_pkg::COLOR_W-1:0]    in_color,
    input  logic                            in_force,
    input  logic                            in_last,
    input  logic [pdrc_pkg::COLOR_W-1:0]    rd_data,
    output pdrc_pkg::store_wr_t             wr,
    output logic                            busy,
    output logic                            res_valid,
    output pdrc_pkg::result_t               res
);

    logic                            p1_valid_reg;
    logic                            p1_range_reg;
    logic [pdrc_pkg::IDX_W-1:0]      p1_idx_reg;
    logic [pdrc_pkg::COLOR_W-1:0]    p1_color_reg;
    logic                            p1_force_reg;
    logic                            p1_last_reg;

    logic                            fwd_valid_reg, fwd_valid_next;
    logic [pdrc_pkg::IDX_W-1:0]      fwd_idx_reg;
    logic [pdrc_pkg::COLOR_W-1:0]    fwd_data_reg;

    logic                            run_active_reg, run_active_next;
    logic [pdrc_pkg::IDX_W-1:0]      run_begin_reg, run_begin_next;
    logic [pdrc_pkg::IDX_W-1:0]      run_end_reg, run_end_next;

    logic [pdrc_pkg::COLOR_W-1:0]    stored;
    logic                            dirty;
    logic                            join_run;
    logic                            close_run;
    logic [pdrc_pkg::IDX_W-1:0]      span_begin, span_end;
    logic [pdrc_pkg::IDX_W-1:0]      out_begin, out_end;

    // The face is found by comparing against the constant face boundaries.
    function automatic logic [pdrc_pkg::FACE_W-1:0] face_of(
        input logic [pdrc_pkg::IDX_W-1:0] idx
    );
        logic [pdrc_pkg::FACE_W-1:0] face;
        face = '0;
        for (int k = 1; k < FACES; k++) begin
            if (32'(idx) >= 32'(k * PANEL_PIXELS)) begin
                face = pdrc_pkg::FACE_W'(k);
            end
        end
        return face;
    endfunction

    always_comb begin
        stored = (fwd_valid_reg && (fwd_idx_reg == p1_idx_reg)) ? fwd_data_reg : rd_data;
        dirty = p1_force_reg || (stored != p1_color_reg);
        join_run = p1_valid_reg && p1_range_reg && dirty;
        close_run = p1_valid_reg && ((!p1_range_reg && p1_last_reg)
                                     || (p1_range_reg && !dirty)
                                     || (join_run && p1_last_reg));

        if (!run_active_reg) begin
            span_begin = p1_idx_reg;
            span_end   = p1_idx_reg;
        end else begin
            span_begin = (p1_idx_reg < run_begin_reg) ? p1_idx_reg : run_begin_reg;
            span_end   = (p1_idx_reg > run_end_reg) ? p1_idx_reg : run_end_reg;
        end

        out_begin = join_run ? span_begin : run_begin_reg;
        out_end   = join_run ? span_end : run_end_reg;

        res_valid = close_run && (run_active_reg || join_run);
        res.run_first  = out_begin;
        res.run_length = pdrc_pkg::LEN_W'(out_end - out_begin + 1'b1);
        res.first_face = face_of(out_begin);
        res.last_face  = face_of(out_end);

        run_active_next = run_active_reg;
        run_begin_next  = run_begin_reg;
        run_end_next    = run_end_reg;
        if (close_run) begin
            run_active_next = 1'b0;
            run_begin_next  = '0;
            run_end_next    = '0;
        end else if (join_run) begin
            run_active_next = 1'b1;
            run_begin_next  = span_begin;
            run_end_next    = span_end;
        end

        fwd_valid_next = join_run;

        wr.en   = join_run;
        wr.idx  = p1_idx_reg;
        wr.data = p1_color_reg;
    end

    assign busy = p1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            run_active_reg <= 1'b0;
            run_begin_reg  <= '0;
            run_end_reg    <= '0;
        end else begin
            p1_valid_reg   <= in_take;
            fwd_valid_reg  <= fwd_valid_next;
            run_active_reg <= run_active_next;
            run_begin_reg  <= run_begin_next;
            run_end_reg    <= run_end_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            p1_range_reg <= in_range;
            p1_idx_reg   <= in_idx;
            p1_color_reg <= in_color;
            p1_force_reg <= in_force;
            p1_last_reg  <= in_last;
        end
        fwd_idx_reg  <= p1_idx_reg;
        fwd_data_reg <= p1_color_reg;
    end

endmodule

/* src/pdrc_out_fifo.sv */
// ----------------------------------------------------------------------------
// pdrc_out_fifo
// Two-entry result queue that decouples the compare stage from the consumer.
// ----------------------------------------------------------------------------
module pdrc_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pdrc_pkg::result_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pdrc_pkg::result_t out_data,
    output logic [1:0]        count
);

    pdrc_pkg::result_t ent_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/pixel_dirty_run_coalescer_top.sv */
// ----------------------------------------------------------------------------
// pixel_dirty_run_coalescer_top
// Pixel store that merges changed pixels into runs and reports each run.
// ----------------------------------------------------------------------------
// The block accepts one pixel item per clock cycle and reports each closed
// dirty run through the compare stage register and a two-entry result
// queue. The rate is set by the single pixel store RAM: each item reads its
// entry in the accept cycle and writes it back, if dirty, in the following
// cycle, with a bypass for back-to-back items on the same pixel. Outside the
// clear, the input stalls when the queued runs plus the item in the compare
// stage, less a run that m_ready takes, would exceed one.
// After reset the store is cleared one entry per cycle, and s_ready stays
// low until every entry is cleared.
module pixel_dirty_run_coalescer_top #(
    parameter int PANEL_PIXELS = pdrc_pkg::PANEL_PIXELS_DEF,
    parameter int FACES        = pdrc_pkg::FACES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pdrc_pkg::IDX_W-1:0]      s_pixel_index,
    input  logic [pdrc_pkg::COLOR_W-1:0]    s_color,
    input  logic                            s_force_req,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pdrc_pkg::IDX_W-1:0]      m_run_first,
    output logic [pdrc_pkg::LEN_W-1:0]      m_run_length,
    output logic [pdrc_pkg::FACE_W-1:0]     m_first_face,
    output logic [pdrc_pkg::FACE_W-1:0]     m_last_face
);

`include "pixel_dirty_run_coalescer_top_macros.svh"

    localparam int PIXEL_TOTAL = PANEL_PIXELS * FACES;
    localparam int AW          = (PIXEL_TOTAL > 1) ? $clog2(PIXEL_TOTAL) : 1;

    pdrc_pkg::state_t              state_reg, state_next;
    logic [AW-1:0]                 clr_cnt_reg, clr_cnt_next;

    logic                          in_take;
    logic                          in_range;
    logic [31:0]                   s_idx_wide;
    logic [31:0]                   wr_idx_wide;

    pdrc_pkg::store_wr_t           upd_wr;
    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [pdrc_pkg::COLOR_W-1:0]  ram_wr_data;
    logic [pdrc_pkg::COLOR_W-1:0]  ram_rd_data;

    logic                          stage_busy;
    logic                          res_valid;
    pdrc_pkg::result_t             res;
    pdrc_pkg::result_t             out_res;
    logic [1:0]                    fifo_count;
    logic                          pop;
    logic [2:0]                    occ_after;

    assign s_idx_wide  = 32'(s_pixel_index);
    assign wr_idx_wide = 32'(upd_wr.idx);
    assign in_range    = (s_idx_wide < 32'(PIXEL_TOTAL));

    assign pop       = m_valid && m_ready;
    assign occ_after = 3'(fifo_count) + 3'(stage_busy) - 3'(pop);
    assign s_ready   = (state_reg == pdrc_pkg::ST_RUN) && (occ_after <= 3'd1);
    assign in_take   = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            pdrc_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == 32'(PIXEL_TOTAL - 1)) begin
                    state_next = pdrc_pkg::ST_RUN;
                end
            end
            pdrc_pkg::ST_RUN: begin
                clr_cnt_next = clr_cnt_reg;
            end
            default: begin
                state_next = pdrc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pdrc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        if (state_reg == pdrc_pkg::ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = upd_wr.en;
            ram_wr_addr = wr_idx_wide[AW-1:0];
            ram_wr_data = upd_wr.data;
        end
    end

    pdrc_ram #(
        .WIDTH (pdrc_pkg::COLOR_W),
        .DEPTH (PIXEL_TOTAL),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_take && in_range),
        .rd_addr (s_idx_wide[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    pdrc_update #(
        .PANEL_PIXELS (PANEL_PIXELS),
        .FACES        (FACES)
    ) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (in_take),
        .in_range  (in_range),
        .in_idx    (s_pixel_index),
        .in_color  (s_color),
        .in_force  (s_force_req),
        .in_last   (s_last),
        .rd_data   (ram_rd_data),
        .wr        (upd_wr),
        .busy      (stage_busy),
        .res_valid (res_valid),
        .res       (res)
    );

    pdrc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    assign m_run_first  = out_res.run_first;
    assign m_run_length = out_res.run_length;
    assign m_first_face = out_res.first_face;
    assign m_last_face  = out_res.last_face;

    `PDRC_ASSERT_IMP(a_no_take_in_clear, state_reg == pdrc_pkg::ST_CLEAR, !s_ready)
    `PDRC_ASSERT_IMP(a_no_fifo_overflow, res_valid, (fifo_count < 2'd2) || m_ready)
    `PDRC_ASSERT_NXT(a_take_enters_stage, in_take, stage_busy)
    `PDRC_ASSERT_IMP(a_no_store_write_clash, upd_wr.en, state_reg == pdrc_pkg::ST_RUN)

endmodule
